>>> hw/rtl/kmp_pkg.sv
package kmp_pkg;

    // Port decode constants
    localparam logic [7:0] PORT_ULA     = 8'hFE;
    localparam int         PORT_JOY_BIT = 5;
    localparam logic [7:0] BORDER_MASK  = 8'h07;
    localparam int         TAPE_IN_BIT  = 6;
    localparam int         TAPE_OUT_BIT = 3;
    localparam logic [7:0] BYTE_ALL     = 8'hFF;

    // Key matrix geometry
    localparam int KEY_ROWS = 8;
    localparam int ROW_W    = 3;

    // Command codes carried in tuser
    typedef enum logic [2:0] {
        CMD_READ        = 3'd0,
        CMD_WRITE       = 3'd1,
        CMD_KEY_PRESS   = 3'd2,
        CMD_KEY_RELEASE = 3'd3,
        CMD_JOY_UPDATE  = 3'd4
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_FAST_MODE   = 1'b0;
    localparam logic CFG_TAPE_OUT_EN = 1'b1;

    // One input transaction
    typedef struct packed {
        logic [2:0]       command;
        logic [7:0]       port_low;
        logic [7:0]       addr_high;
        logic [7:0]       data_byte;
        logic [ROW_W-1:0] key_row;
        logic [31:0]      cycle_stamp;
        logic             tape_in_level;
        logic             tape_idle;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [7:0]         read_data;
        logic [2:0]         border_color;
        logic               sound_write;
        logic [7:0]         sound_value;
        logic               tape_edge;
        logic signed [31:0] tape_interval;
    } t_result;

    // Key matrix update request
    typedef struct packed {
        logic             en;
        logic             press;
        logic [ROW_W-1:0] row;
        logic [7:0]       mask;
    } t_key_upd;

endpackage

>>> hw/rtl/keyboard_matrix_port_io.sv
// Channel   Direction  Signals                     Content
// s (in)    input      i_s_tvalid/o_s_tready       one port access or key/joystick event
// m (out)   output     o_m_tvalid/i_m_tready       one result per input transaction
// cfg       input      i_cfg_we/i_cfg_index/wdata  fast_mode, tape_out_enable
//
// One transaction per cycle sustained while results are taken; an accepted input
// passes through the input register, then the result register.
// Reset is synchronous, active low: key matrix all released, valid flags, configuration and port state zero.
// A stalled result holds the result register; the input register still takes
// one more transaction, then s_tready drops until the result is taken.
module keyboard_matrix_port_io import kmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg: register index 0 fast_mode, 1 tape_out_enable
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // port_low[7:0], addr_high[15:8], data_byte[23:16], key_row[26:24],
    // cycle_stamp[58:27], tape_in_level[59], tape_idle[60], zero[63:61]
    input  logic [63:0] i_s_tdata,
    // command[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[7:0], border_color[10:8], sound_write[11], sound_value[19:12],
    // tape_edge[20], tape_interval[52:21], zero[55:53]
    output logic [55:0] o_m_tdata
);

    logic    r_in_valid;
    t_item   r_item;
    t_item   n_item;
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;
    logic    r_fast_mode;
    logic    r_tape_out_en;
    logic    w_advance;

    // Advance when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // Unpack the input transaction
    always_comb begin
        n_item.command       = i_s_tuser;
        n_item.port_low      = i_s_tdata[7:0];
        n_item.addr_high     = i_s_tdata[15:8];
        n_item.data_byte     = i_s_tdata[23:16];
        n_item.key_row       = i_s_tdata[26:24];
        n_item.cycle_stamp   = i_s_tdata[58:27];
        n_item.tape_in_level = i_s_tdata[59];
        n_item.tape_idle     = i_s_tdata[60];
    end

    kmp_port u_port (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_item        (r_item),
        .i_fast_mode   (r_fast_mode),
        .i_tape_out_en (r_tape_out_en),
        .o_result      (w_result)
    );

    // Hold valid flags and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fast_mode   <= 1'b0;
            r_tape_out_en <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FAST_MODE:   r_fast_mode   <= i_cfg_wdata;
                    CFG_TAPE_OUT_EN: r_tape_out_en <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Load payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= n_item;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000,
                         r_result.tape_interval,
                         r_result.tape_edge,
                         r_result.sound_value,
                         r_result.sound_write,
                         r_result.border_color,
                         r_result.read_data};

`ifndef SYNTHESIS
    // Result register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Full input register with stalled result blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while both stages are full and stalled");

    // An item waiting ahead of an empty result register moves on next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_m_tvalid) |=> o_m_tvalid)
        else $error("item did not advance into empty result register");
`endif

endmodule

>>> hw/rtl/kmp_keys.sv
module kmp_keys import kmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_key_upd   i_upd,
    input  logic [7:0] i_sel,
    output logic [7:0] o_row_and
);

    logic [7:0] r_rows [KEY_ROWS];

    // Clear or set mask bits in the addressed row; reset releases all keys
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_rows[i] <= BYTE_ALL;
            end
        end else begin
            for (int i = 0; i < KEY_ROWS; i++) begin
                if (i_upd.en && (i_upd.row == ROW_W'(i))) begin
                    if (i_upd.press) begin
                        r_rows[i] <= r_rows[i] & ~i_upd.mask;
                    end else begin
                        r_rows[i] <= r_rows[i] | i_upd.mask;
                    end
                end
            end
        end
    end

    // AND every row whose select bit is low
    always_comb begin
        o_row_and = BYTE_ALL;
        for (int i = 0; i < KEY_ROWS; i++) begin
            if (!i_sel[i]) begin
                o_row_and = o_row_and & r_rows[i];
            end
        end
    end

endmodule

>>> hw/rtl/kmp_port.sv
module kmp_port import kmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  logic    i_fast_mode,
    input  logic    i_tape_out_en,
    output t_result o_result
);

    logic [7:0]  r_joy;
    logic        r_tape_level;
    logic [31:0] r_last_stamp;
    logic [2:0]  r_border;

    logic [7:0]  n_joy;
    logic        n_tape_level;
    logic [31:0] n_last_stamp;
    logic [2:0]  n_border;

    t_key_upd    w_key_upd;
    logic [7:0]  w_row_and;
    logic        w_lvl;

    kmp_keys u_keys (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (w_key_upd),
        .i_sel     (i_item.addr_high),
        .o_row_and (w_row_and)
    );

    assign w_lvl = i_item.data_byte[TAPE_OUT_BIT];

    // Decode the command and form the result and next state
    always_comb begin
        n_joy        = r_joy;
        n_tape_level = r_tape_level;
        n_last_stamp = r_last_stamp;
        n_border     = r_border;
        o_result     = '0;
        w_key_upd    = '0;
        w_key_upd.row  = i_item.key_row;
        w_key_upd.mask = i_item.data_byte;

        case (i_item.command)
            CMD_READ: begin
                if (!i_item.port_low[PORT_JOY_BIT]) begin
                    o_result.read_data = r_joy;
                end else if (i_item.port_low[0]) begin
                    o_result.read_data = BYTE_ALL;
                end else begin
                    o_result.read_data = w_row_and;
                    o_result.read_data[TAPE_IN_BIT] = i_item.tape_in_level;
                end
            end
            CMD_WRITE: begin
                if (i_item.port_low == PORT_ULA) begin
                    n_border = 3'(i_item.data_byte & BORDER_MASK);
                    if (!i_fast_mode && i_item.tape_idle) begin
                        o_result.sound_write = 1'b1;
                        o_result.sound_value = i_item.data_byte;
                    end
                    if (w_lvl != r_tape_level) begin
                        n_tape_level = w_lvl;
                        n_last_stamp = i_item.cycle_stamp;
                        if (i_tape_out_en) begin
                            o_result.tape_edge     = 1'b1;
                            o_result.tape_interval =
                                $signed(i_item.cycle_stamp - r_last_stamp);
                        end
                    end
                end
            end
            CMD_KEY_PRESS: begin
                w_key_upd.en    = i_en;
                w_key_upd.press = 1'b1;
            end
            CMD_KEY_RELEASE: begin
                w_key_upd.en    = i_en;
                w_key_upd.press = 1'b0;
            end
            CMD_JOY_UPDATE: begin
                n_joy = i_item.data_byte;
            end
            default: begin
            end
        endcase

        o_result.border_color = n_border;
    end

    // Commit state when the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joy        <= '0;
            r_tape_level <= 1'b0;
            r_last_stamp <= '0;
            r_border     <= '0;
        end else if (i_en) begin
            r_joy        <= n_joy;
            r_tape_level <= n_tape_level;
            r_last_stamp <= n_last_stamp;
            r_border     <= n_border;
        end
    end

endmodule
